>>> rtl/smsmm_pkg.sv
// Shared constants, state encoding and controller/datapath interface types.
package smsmm_pkg;

  localparam int unsigned MAX_SAMPLES = 4096;

  localparam int unsigned SMP_W      = 24;
  localparam int unsigned CNT_W      = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W      = 36;
  localparam int unsigned SQ_W       = 60;
  localparam int unsigned PROD_W     = 2 * SMP_W;
  localparam int unsigned STD_W      = 23;
  localparam int unsigned ROOT_W     = SQ_W / 2;
  localparam int unsigned DIV_CNT_W  = $clog2(SQ_W);
  localparam int unsigned ROOT_CNT_W = $clog2(ROOT_W);

  localparam logic [STD_W-1:0] STD_MAX = '1;

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_DRAIN     = 9'b000000010,
    ST_SUM_GO    = 9'b000000100,
    ST_SUM_WAIT  = 9'b000001000,
    ST_SQ_GO     = 9'b000010000,
    ST_SQ_WAIT   = 9'b000100000,
    ST_ROOT_GO   = 9'b001000000,
    ST_ROOT_WAIT = 9'b010000000,
    ST_EMIT      = 9'b100000000
  } state_e;

  typedef struct packed {
    logic accept;      // input transaction taken this cycle
    logic div_start;
    logic div_sel_sq;  // 0: divide |sum|, 1: divide sum of squares
    logic mean_load;
    logic root_start;
    logic emit;        // publish result and clear accumulators
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic root_done;
  } ctrl_sts_t;

endpackage

>>> rtl/sample_mean_stddev_min_max.sv
// Running mean, population std deviation, min, max and count over Q16.8 samples.
// Throughput: one sample per cycle while busy is low; the two-stage square/accumulate
// pipe sets that. A sample marked last raises busy; done_o pulses once two 60-step
// restoring divides and a 30-step square root are through, and busy drops then.
// The receiver cannot stall: results are valid from the done_o cycle until the next one.
// Reset (rst_ni low, asynchronous) clears all accumulators and returns to idle.
module sample_mean_stddev_min_max import smsmm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [SMP_W-1:0] sample_i,
  input  logic                    last_sample_i,
  output logic                    done_o,
  output logic signed [SMP_W-1:0] mean_value_o,
  output logic        [STD_W-1:0] std_dev_o,
  output logic signed [SMP_W-1:0] min_value_o,
  output logic signed [SMP_W-1:0] max_value_o,
  output logic        [CNT_W-1:0] sample_count_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  smsmm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .last_sample_i (last_sample_i),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .busy_o        (busy)
  );

  smsmm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_i       (sample_i),
    .done_o         (done_o),
    .mean_value_o   (mean_value_o),
    .std_dev_o      (std_dev_o),
    .min_value_o    (min_value_o),
    .max_value_o    (max_value_o),
    .sample_count_o (sample_count_o)
  );

endmodule

>>> rtl/smsmm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module smsmm_div import smsmm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SQ_W-1:0]  dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic [SQ_W-1:0]  quot_o,
  output logic             done_o
);

  logic                 run_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0]     rem_q;
  logic [SQ_W-1:0]      quo_q;

  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   trial_diff;
  logic             fits;
  logic [CNT_W-1:0] rem_d;

  assign trial      = {rem_q, quo_q[SQ_W-1]};
  assign fits       = (trial >= {1'b0, divisor_i});
  assign trial_diff = trial - {1'b0, divisor_i};
  // remainder stays below the divisor, so the top bit drops out
  assign rem_d      = fits ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == DIV_CNT_W'(SQ_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[SQ_W-2:0], fits};
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

>>> rtl/smsmm_sqrt.sv
// Restoring integer square root, one root bit (two radicand bits) per cycle.
module smsmm_sqrt import smsmm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   radicand_i,
  output logic [ROOT_W-1:0] root_o,
  output logic              done_o
);

  logic                  run_q;
  logic                  done_q;
  logic [ROOT_CNT_W-1:0] cnt_q;
  logic [SQ_W-1:0]       x_q;
  logic [ROOT_W:0]       rem_q;
  logic [ROOT_W-1:0]     root_q;

  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] rem_diff;
  logic              fits;
  logic [ROOT_W:0]   rem_d;

  assign rem_sh   = {rem_q, x_q[SQ_W-1 -: 2]};
  assign trial    = {1'b0, root_q, 2'b01};
  assign fits     = (rem_sh >= trial);
  assign rem_diff = rem_sh - trial;
  // remainder never exceeds twice the partial root
  assign rem_d    = fits ? rem_diff[ROOT_W:0] : rem_sh[ROOT_W:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == ROOT_CNT_W'(ROOT_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      x_q    <= {x_q[SQ_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

>>> rtl/smsmm_dp.sv
// Datapath: square stage, accumulators, mean/variance arithmetic, result registers.
module smsmm_dp import smsmm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_cmd_t               cmd_i,
  output ctrl_sts_t               sts_o,
  input  logic signed [SMP_W-1:0] sample_i,
  output logic                    done_o,
  output logic signed [SMP_W-1:0] mean_value_o,
  output logic        [STD_W-1:0] std_dev_o,
  output logic signed [SMP_W-1:0] min_value_o,
  output logic signed [SMP_W-1:0] max_value_o,
  output logic        [CNT_W-1:0] sample_count_o
);

  // square stage
  logic                    st_vld_q;
  logic signed [SMP_W-1:0] st_s_q;
  logic        [PROD_W-1:0] st_sq_q;
  logic signed [PROD_W-1:0] smp_prod;

  // accumulators
  logic signed [SUM_W-1:0] sum_q;
  logic        [SQ_W-1:0]  sq_q;
  logic signed [SMP_W-1:0] min_q;
  logic signed [SMP_W-1:0] max_q;
  logic        [CNT_W-1:0] cnt_q;

  // result arithmetic
  logic                     sum_neg;
  logic        [SUM_W-1:0]  sum_mag;
  logic        [SQ_W-1:0]   div_dividend;
  logic        [SQ_W-1:0]   div_quot;
  logic        [SMP_W-1:0]  mean_mag;
  logic signed [SMP_W-1:0]  mean_q;
  logic signed [PROD_W-1:0] mean_prod;
  logic        [PROD_W-1:0] mean_sq_q;
  logic        [SQ_W:0]     var_diff;
  logic        [SQ_W-1:0]   var_op;
  logic        [ROOT_W-1:0] root;

  logic                    done_q;
  logic signed [SMP_W-1:0] mean_out_q;
  logic        [STD_W-1:0] std_out_q;
  logic signed [SMP_W-1:0] min_out_q;
  logic signed [SMP_W-1:0] max_out_q;
  logic        [CNT_W-1:0] cnt_out_q;

  assign smp_prod = sample_i * sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= 1'b0;
    end else begin
      st_vld_q <= cmd_i.accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      st_s_q  <= sample_i;
      st_sq_q <= smp_prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      sq_q  <= '0;
      min_q <= '0;
      max_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.emit) begin
      sum_q <= '0;
      sq_q  <= '0;
      min_q <= '0;
      max_q <= '0;
      cnt_q <= '0;
    end else if (st_vld_q && (cnt_q != CNT_W'(MAX_SAMPLES))) begin
      // once the count is saturated further samples are dropped entirely
      sum_q <= sum_q + SUM_W'(st_s_q);
      sq_q  <= sq_q + SQ_W'(st_sq_q);
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == '0) begin
        min_q <= st_s_q;
        max_q <= st_s_q;
      end else begin
        if (st_s_q < min_q) min_q <= st_s_q;
        if (st_s_q > max_q) max_q <= st_s_q;
      end
    end
  end

  // mean truncates toward zero: divide the magnitude, restore the sign
  assign sum_neg      = sum_q[SUM_W-1];
  assign sum_mag      = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign div_dividend = cmd_i.div_sel_sq ? sq_q : SQ_W'(sum_mag);

  smsmm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cnt_q),
    .quot_o     (div_quot),
    .done_o     (sts_o.div_done)
  );

  assign mean_mag  = div_quot[SMP_W-1:0];
  assign mean_prod = mean_q * mean_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_load) begin
      mean_q <= sum_neg ? SMP_W'(-mean_mag) : mean_mag;
    end
    mean_sq_q <= PROD_W'(mean_prod);
  end

  // quotient now holds floor(sum_sq / n); negative variance clamps to zero
  assign var_diff = (SQ_W + 1)'(div_quot) - (SQ_W + 1)'(mean_sq_q);
  assign var_op   = var_diff[SQ_W] ? '0 : var_diff[SQ_W-1:0];

  smsmm_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.root_start),
    .radicand_i (var_op),
    .root_o     (root),
    .done_o     (sts_o.root_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      mean_out_q <= mean_q;
      std_out_q  <= (root > ROOT_W'(STD_MAX)) ? STD_MAX : root[STD_W-1:0];
      min_out_q  <= min_q;
      max_out_q  <= max_q;
      cnt_out_q  <= cnt_q;
    end
  end

  assign done_o         = done_q;
  assign mean_value_o   = mean_out_q;
  assign std_dev_o      = std_out_q;
  assign min_value_o    = min_out_q;
  assign max_value_o    = max_out_q;
  assign sample_count_o = cnt_out_q;

endmodule

>>> rtl/smsmm_ctrl.sv
// Controller: accepts samples and sequences the end-of-run divides and square root.
module smsmm_ctrl import smsmm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      last_sample_i,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o,
  output logic      busy_o
);

  state_e state_q, state_d;
  logic   busy;
  logic   accept;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start_i && !busy;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.accept = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && last_sample_i) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        // final sample lands in the accumulators this cycle
        state_d = ST_SUM_GO;
      end
      ST_SUM_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_SUM_WAIT;
      end
      ST_SUM_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.mean_load = 1'b1;
          state_d = ST_SQ_GO;
        end
      end
      ST_SQ_GO: begin
        cmd_o.div_start  = 1'b1;
        cmd_o.div_sel_sq = 1'b1;
        state_d = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        cmd_o.div_sel_sq = 1'b1;
        if (sts_i.div_done) state_d = ST_ROOT_GO;
      end
      ST_ROOT_GO: begin
        cmd_o.root_start = 1'b1;
        state_d = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (sts_i.root_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = busy;

endmodule
